// File: sv/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg: shared types and constants of the music board port block
// action codes, port numbers, counter mode fields and the timer command
// ----------------------------------------------------------------------------
package mbp_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    // port numbers on the select field
    localparam logic [2:0] PORT_A       = 3'd0;
    localparam logic [2:0] PORT_B       = 3'd1;
    localparam logic [2:0] PORT_C       = 3'd2;
    localparam logic [2:0] PORT_STATUS  = 3'd3;
    localparam logic [2:0] PORT_ENABLE0 = 3'd4;
    localparam logic [2:0] PORT_ENABLE1 = 3'd5;
    localparam logic [2:0] PORT_COUNT   = 3'd6;
    localparam logic [2:0] PORT_CONTROL = 3'd7;

    // fixed bytes returned on reads of the status and control ports
    localparam logic [7:0] STATUS_BYTE  = 8'h08;
    localparam logic [7:0] CONTROL_BYTE = 8'h80;

    // counter access field (mode bits 5:4)
    localparam logic [1:0] ACC_LATCH = 2'b00;
    localparam logic [1:0] ACC_LOW   = 2'b01;
    localparam logic [1:0] ACC_HIGH  = 2'b10;
    localparam logic [1:0] ACC_WORD  = 2'b11;

    // counter operating mode field (mode bits 3:2) that reloads at zero
    localparam logic [1:0] OPMODE_RATE = 2'b01;

    localparam logic [15:0] MIN_RELOAD = 16'd4;
    localparam logic [16:0] FULL_COUNT = 17'h10000;

    typedef struct packed {
        logic       ctrl_wr;
        logic       count_wr;
        logic       count_rd;
        logic       tick;
        logic [7:0] data;
    } timer_cmd_t;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       irq;
    } timer_rsp_t;

endpackage

// File: sv/mbp_timer.sv
// ----------------------------------------------------------------------------
// mbp_timer: single interval counter
// low, high and word count access, latch command, one-shot or rate reload
// ----------------------------------------------------------------------------
module mbp_timer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  mbp_pkg::timer_cmd_t cmd,
    output mbp_pkg::timer_rsp_t rsp
);
    import mbp_pkg::*;

    logic [7:0]  mode_reg, mode_next;
    logic        wr_tog_reg, wr_tog_next;
    logic        rd_tog_reg, rd_tog_next;
    logic [15:0] reload_reg, reload_next;
    logic [15:0] latched_reg, latched_next;
    logic [16:0] remain_reg, remain_next;
    logic        running_reg, running_next;

    logic [1:0]  access;
    logic [15:0] cur_count;
    logic [15:0] rd_word;
    logic        start;
    logic [15:0] start_reload;

    assign access    = mode_reg[5:4];
    assign cur_count = running_reg ? remain_reg[15:0] : 16'd0;
    assign rd_word   = (access != ACC_LATCH) ? cur_count : latched_reg;

    always_comb begin
        mode_next    = mode_reg;
        wr_tog_next  = wr_tog_reg;
        rd_tog_next  = rd_tog_reg;
        reload_next  = reload_reg;
        latched_next = latched_reg;
        remain_next  = remain_reg;
        running_next = running_reg;
        start        = 1'b0;
        start_reload = reload_reg;
        rsp          = '0;

        if (cmd.ctrl_wr) begin
            wr_tog_next = 1'b0;
            rd_tog_next = 1'b0;
            if (cmd.data[5:4] != ACC_LATCH) begin
                mode_next = cmd.data;
            end else begin
                mode_next    = {mode_reg[7:6], ACC_LATCH, mode_reg[3:0]};
                latched_next = cur_count;
            end
        end

        if (cmd.count_wr) begin
            case (access)
                ACC_LOW: begin
                    reload_next = {8'h00, cmd.data};
                    start       = 1'b1;
                end
                ACC_HIGH: begin
                    reload_next = {cmd.data, 8'h00};
                    start       = 1'b1;
                end
                ACC_WORD: begin
                    wr_tog_next = ~wr_tog_reg;
                    if (!wr_tog_reg) begin
                        reload_next = {reload_reg[15:8], cmd.data};
                    end else begin
                        reload_next = {cmd.data, reload_reg[7:0]};
                        start       = 1'b1;
                    end
                end
                default: begin
                    start = 1'b1;
                end
            endcase
            start_reload = reload_next;
        end

        if (cmd.count_rd) begin
            case (access)
                ACC_LOW:  rsp.rd_data = rd_word[7:0];
                ACC_HIGH: rsp.rd_data = rd_word[15:8];
                default: begin
                    rsp.rd_data = rd_tog_reg ? rd_word[15:8] : rd_word[7:0];
                    rd_tog_next = ~rd_tog_reg;
                end
            endcase
        end

        if (cmd.tick && running_reg) begin
            if (remain_reg[16:1] == 16'd0) begin
                rsp.irq = 1'b1;
                if (mode_reg[3:2] == OPMODE_RATE) begin
                    start = 1'b1;
                end else begin
                    remain_next  = '0;
                    running_next = 1'b0;
                end
            end else begin
                remain_next = 17'(remain_reg - 17'd1);
            end
        end

        // load the count: short reloads run the full range
        if (start) begin
            remain_next  = (start_reload > MIN_RELOAD) ? {1'b0, start_reload} : FULL_COUNT;
            running_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            wr_tog_reg  <= 1'b0;
            rd_tog_reg  <= 1'b0;
            reload_reg  <= '0;
            latched_reg <= '0;
            remain_reg  <= '0;
            running_reg <= 1'b0;
        end else if (en) begin
            mode_reg    <= mode_next;
            wr_tog_reg  <= wr_tog_next;
            rd_tog_reg  <= rd_tog_next;
            reload_reg  <= reload_next;
            latched_reg <= latched_next;
            remain_reg  <= remain_next;
            running_reg <= running_next;
        end
    end

endmodule

// File: sv/music_board_ports_with_interval_timer_unit.sv
// ----------------------------------------------------------------------------
// music_board_ports_with_interval_timer_unit: sound board port block
// ports A/B/C, tone enable mask, key-load sequencer and one interval counter
// ----------------------------------------------------------------------------
// result path: an accepted item is held in the input register, then moves
//   on into the result register
// throughput: one item per cycle sustained while m_ready is high, set by the
//   single update stage between the two registers
// reset: synchronous active-low aresetn clears all ports, the sequencer and the
//   counter (stopped), and empties both registers
module music_board_ports_with_interval_timer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // input item channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [2:0] s_port_select,
    input  logic [7:0] s_write_data,
    // result item channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_pulse,
    output logic       m_key_strobe,
    output logic [2:0] m_key_channel,
    output logic [7:0] m_key_value,
    output logic       m_enable_strobe,
    output logic [7:0] m_enable_value
);
    import mbp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_action_reg;
    logic [2:0] in_port_reg;
    logic [7:0] in_data_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_read_data_reg;
    logic       out_irq_reg;
    logic       out_key_strobe_reg;
    logic [2:0] out_key_channel_reg;
    logic [7:0] out_key_value_reg;
    logic       out_enable_strobe_reg;
    logic [7:0] out_enable_value_reg;

    // port and sequencer state
    logic [7:0] port_a_reg, port_a_next;
    logic [7:0] port_b_reg, port_b_next;
    logic [7:0] port_c_reg, port_c_next;
    logic [7:0] enable_reg, enable_next;
    logic       armed_reg, armed_next;
    logic [2:0] chan_reg, chan_next;

    // per-item results before the result register
    logic [7:0] rd_data;
    logic       key_stb;
    logic [2:0] key_ch;
    logic [7:0] key_val;
    logic       en_stb;

    logic       advance;
    logic       is_write;
    logic       is_read;
    timer_cmd_t tmr_cmd;
    timer_rsp_t tmr_rsp;

    // item moves from the input register into the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign is_write = (in_action_reg == ACT_WRITE);
    assign is_read  = (in_action_reg == ACT_READ);

    // counter commands decoded from the held item
    always_comb begin
        tmr_cmd          = '0;
        tmr_cmd.data     = in_data_reg;
        tmr_cmd.ctrl_wr  = is_write && (in_port_reg == PORT_CONTROL);
        tmr_cmd.count_wr = is_write && (in_port_reg == PORT_COUNT);
        tmr_cmd.count_rd = is_read && (in_port_reg == PORT_COUNT);
        tmr_cmd.tick     = (in_action_reg == ACT_TICK);
    end

    mbp_timer u_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .cmd     (tmr_cmd),
        .rsp     (tmr_rsp)
    );

    // port writes, key sequencer and read mux
    always_comb begin
        port_a_next = port_a_reg;
        port_b_next = port_b_reg;
        port_c_next = port_c_reg;
        enable_next = enable_reg;
        armed_next  = armed_reg;
        chan_next   = chan_reg;
        rd_data     = '0;
        key_stb     = 1'b0;
        key_ch      = '0;
        key_val     = '0;
        en_stb      = 1'b0;

        if (is_write) begin
            case (in_port_reg)
                PORT_A: port_a_next = in_data_reg;
                PORT_B: port_b_next = in_data_reg;
                PORT_C: begin
                    if (in_data_reg[7]) begin
                        if (!port_c_reg[7]) begin
                            // rising bit 7 arms at the first channel
                            armed_next = 1'b1;
                            chan_next  = '0;
                        end else if (armed_reg) begin
                            // armed: this byte is the key for the channel
                            armed_next = 1'b0;
                            key_stb    = 1'b1;
                            key_ch     = chan_reg;
                            key_val    = in_data_reg;
                        end else if (!in_data_reg[6] && port_c_reg[6]) begin
                            // falling bit 6 steps to the next channel
                            armed_next = 1'b1;
                            chan_next  = 3'(chan_reg + 3'd1);
                        end
                    end
                    port_c_next = in_data_reg;
                end
                PORT_ENABLE0, PORT_ENABLE1: begin
                    enable_next = in_data_reg;
                    en_stb      = 1'b1;
                end
                default: ;  // status, count and control ports need nothing here
            endcase
        end else if (is_read) begin
            case (in_port_reg)
                PORT_A:                     rd_data = port_a_reg;
                PORT_B:                     rd_data = port_b_reg;
                PORT_C:                     rd_data = port_c_reg;
                PORT_STATUS:                rd_data = STATUS_BYTE;
                PORT_ENABLE0, PORT_ENABLE1: rd_data = enable_reg;
                PORT_COUNT:                 rd_data = tmr_rsp.rd_data;
                default:                    rd_data = CONTROL_BYTE;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_port_reg   <= s_port_select;
            in_data_reg   <= s_write_data;
        end
    end

    // block state, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_a_reg <= '0;
            port_b_reg <= '0;
            port_c_reg <= '0;
            enable_reg <= '0;
            armed_reg  <= 1'b0;
            chan_reg   <= '0;
        end else if (advance) begin
            port_a_reg <= port_a_next;
            port_b_reg <= port_b_next;
            port_c_reg <= port_c_next;
            enable_reg <= enable_next;
            armed_reg  <= armed_next;
            chan_reg   <= chan_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_read_data_reg     <= rd_data;
            out_irq_reg           <= tmr_rsp.irq;
            out_key_strobe_reg    <= key_stb;
            out_key_channel_reg   <= key_ch;
            out_key_value_reg     <= key_val;
            out_enable_strobe_reg <= en_stb;
            out_enable_value_reg  <= enable_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = out_read_data_reg;
    assign m_irq_pulse     = out_irq_reg;
    assign m_key_strobe    = out_key_strobe_reg;
    assign m_key_channel   = out_key_channel_reg;
    assign m_key_value     = out_key_value_reg;
    assign m_enable_strobe = out_enable_strobe_reg;
    assign m_enable_value  = out_enable_value_reg;

    // a key byte always carries bit 7
    a_key_bit7: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_key_strobe_reg) |-> out_key_value_reg[7])
        else $error("key item without bit 7");

    // one item never both delivers a key and writes the enable mask
    a_strobe_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_key_strobe_reg && out_enable_strobe_reg))
        else $error("key and enable strobes together");

    // an interrupt comes only from a tick, which returns no data
    a_irq_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_irq_reg) |->
            (out_read_data_reg == 8'd0 && !out_key_strobe_reg && !out_enable_strobe_reg))
        else $error("interrupt on a bus access item");

    // an item that advances shows up in the result register
    a_advance_src: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

endmodule

// File: sim/board_result_checker.sv
// ----------------------------------------------------------------------------
// board_result_checker: result predictor and comparator for the port block
// tracks the ports, key sequencer and interval counter from accepted items
// and compares every delivered result field by field with the oldest due one
// ----------------------------------------------------------------------------
module board_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [2:0] s_port_select,
    input  logic [7:0] s_write_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_read_data,
    input  logic       m_irq_pulse,
    input  logic       m_key_strobe,
    input  logic [2:0] m_key_channel,
    input  logic [7:0] m_key_value,
    input  logic       m_enable_strobe,
    input  logic [7:0] m_enable_value,
    output int         mismatches,
    output int         outstanding
);
    import mbp_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       key_stb;
        logic [2:0] key_ch;
        logic [7:0] key_val;
        logic       en_stb;
        logic [7:0] en_val;
    } board_result_t;

    board_result_t results_due[$];
    int            results_seen = 0;

    // shadow of the block state
    logic [7:0]  port_a, port_b, port_c, tone_mask, mode;
    logic        key_armed;
    logic [2:0]  key_chan;
    logic        wr_hi_next, rd_hi_next;
    logic [15:0] reload, latch_word;
    logic [16:0] remaining;
    logic        running;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic flag_error(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s got %h want %h",
                                 results_seen, name, got, want));
    endtask

    function automatic logic [15:0] live_count();
        return running ? remaining[15:0] : 16'd0;
    endfunction

    task automatic load_counter();
        remaining = (reload > MIN_RELOAD) ? {1'b0, reload} : FULL_COUNT;
        running   = 1'b1;
    endtask

    task automatic update_board(input logic [1:0] act, input logic [2:0] port,
                                input logic [7:0] data, output board_result_t r);
        logic [15:0] w;
        r = '0;
        case (act)
            ACT_WRITE: begin
                case (port)
                    PORT_A: port_a = data;
                    PORT_B: port_b = data;
                    PORT_C: begin
                        if (data[7]) begin
                            if (!port_c[7]) begin
                                key_armed = 1'b1;
                                key_chan  = 3'd0;
                            end else if (key_armed) begin
                                key_armed = 1'b0;
                                r.key_stb = 1'b1;
                                r.key_ch  = key_chan;
                                r.key_val = data;
                            end else if (!data[6] && port_c[6]) begin
                                key_armed = 1'b1;
                                key_chan  = key_chan + 3'd1;
                            end
                        end
                        port_c = data;
                    end
                    PORT_STATUS: ;
                    PORT_ENABLE0, PORT_ENABLE1: begin
                        tone_mask = data;
                        r.en_stb  = 1'b1;
                    end
                    PORT_COUNT: begin
                        case (mode[5:4])
                            ACC_LOW: begin
                                reload = {8'h00, data};
                                load_counter();
                            end
                            ACC_HIGH: begin
                                reload = {data, 8'h00};
                                load_counter();
                            end
                            ACC_WORD: begin
                                if (!wr_hi_next) begin
                                    reload[7:0] = data;
                                    wr_hi_next  = 1'b1;
                                end else begin
                                    reload[15:8] = data;
                                    wr_hi_next   = 1'b0;
                                    load_counter();
                                end
                            end
                            default: load_counter();
                        endcase
                    end
                    default: begin
                        wr_hi_next = 1'b0;
                        rd_hi_next = 1'b0;
                        if (data[5:4] != ACC_LATCH) begin
                            mode = data;
                        end else begin
                            mode[5:4]  = ACC_LATCH;
                            latch_word = live_count();
                        end
                    end
                endcase
            end
            ACT_READ: begin
                case (port)
                    PORT_A:                     r.read_data = port_a;
                    PORT_B:                     r.read_data = port_b;
                    PORT_C:                     r.read_data = port_c;
                    PORT_STATUS:                r.read_data = STATUS_BYTE;
                    PORT_ENABLE0, PORT_ENABLE1: r.read_data = tone_mask;
                    PORT_COUNT: begin
                        w = (mode[5:4] != ACC_LATCH) ? live_count() : latch_word;
                        case (mode[5:4])
                            ACC_LOW:  r.read_data = w[7:0];
                            ACC_HIGH: r.read_data = w[15:8];
                            default: begin
                                r.read_data = rd_hi_next ? w[15:8] : w[7:0];
                                rd_hi_next  = !rd_hi_next;
                            end
                        endcase
                    end
                    default: r.read_data = CONTROL_BYTE;
                endcase
            end
            ACT_TICK: begin
                if (running) begin
                    if (remaining <= 17'd1) begin
                        r.irq = 1'b1;
                        if (mode[3:2] == OPMODE_RATE) begin
                            load_counter();
                        end else begin
                            remaining = '0;
                            running   = 1'b0;
                        end
                    end else begin
                        remaining = remaining - 17'd1;
                    end
                end
            end
            default: ;
        endcase
        r.en_val = tone_mask;
    endtask

    always @(posedge aclk) begin
        board_result_t want, got;
        if (!aresetn) begin
            port_a     = '0;
            port_b     = '0;
            port_c     = '0;
            tone_mask  = '0;
            mode       = '0;
            key_armed  = 1'b0;
            key_chan   = '0;
            wr_hi_next = 1'b0;
            rd_hi_next = 1'b0;
            reload     = '0;
            latch_word = '0;
            remaining  = '0;
            running    = 1'b0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_read_data, m_irq_pulse, m_key_strobe, m_key_channel,
                        m_key_value, m_enable_strobe, m_enable_value};
                if (results_due.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing due",
                                         results_seen));
                end else begin
                    want = results_due.pop_front();
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("irq_pulse", {7'd0, got.irq}, {7'd0, want.irq});
                    check_field("key_strobe", {7'd0, got.key_stb},
                                {7'd0, want.key_stb});
                    check_field("key_channel", {5'd0, got.key_ch},
                                {5'd0, want.key_ch});
                    check_field("key_value", got.key_val, want.key_val);
                    check_field("enable_strobe", {7'd0, got.en_stb},
                                {7'd0, want.en_stb});
                    check_field("enable_value", got.en_val, want.en_val);
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                update_board(s_action, s_port_select, s_write_data, want);
                results_due.push_back(want);
            end
        end
        outstanding = results_due.size();
    end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the music board port block
// directed port, key sequencer and counter items, then random sequences with
// idling on both sides; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module testbench;
    import mbp_pkg::*;

    // the action code the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS    = 730;
    localparam int CALM_ITEMS     = 120;   // final stretch without idling
    localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
    localparam int DRAIN_CYCLES   = 10;    // margin after the block has drained

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_action;
    logic [2:0] s_port_select;
    logic [7:0] s_write_data;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_read_data;
    logic       m_irq_pulse;
    logic       m_key_strobe;
    logic [2:0] m_key_channel;
    logic [7:0] m_key_value;
    logic       m_enable_strobe;
    logic [7:0] m_enable_value;

    int errors;
    int outstanding;
    int items_sent;
    int stall_left;
    int idle_cycles = 0;
    bit src_gaps;
    bit sink_stalls;
    bit hold_req;
    bit paused_once;

    always #1 aclk = ~aclk;

    music_board_ports_with_interval_timer_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_port_select   (s_port_select),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq_pulse     (m_irq_pulse),
        .m_key_strobe    (m_key_strobe),
        .m_key_channel   (m_key_channel),
        .m_key_value     (m_key_value),
        .m_enable_strobe (m_enable_strobe),
        .m_enable_value  (m_enable_value)
    );

    board_result_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_port_select   (s_port_select),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq_pulse     (m_irq_pulse),
        .m_key_strobe    (m_key_strobe),
        .m_key_channel   (m_key_channel),
        .m_key_value     (m_key_value),
        .m_enable_strobe (m_enable_strobe),
        .m_enable_value  (m_enable_value),
        .mismatches      (errors),
        .outstanding     (outstanding)
    );

    // offer one item from a falling edge and hold it until it is taken;
    // returns on the falling edge after the accepting rising edge
    task automatic send_item(input logic [1:0] act, input logic [2:0] port,
                             input logic [7:0] data);
        if (src_gaps && $urandom_range(0, 9) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_action      = act;
        s_port_select = port;
        s_write_data  = data;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_port(input logic [2:0] port, input logic [7:0] data);
        send_item(ACT_WRITE, port, data);
    endtask

    task automatic read_port(input logic [2:0] port);
        send_item(ACT_READ, port, 8'($urandom));
    endtask

    task automatic tick();
        send_item(ACT_TICK, 3'($urandom), 8'($urandom));
    endtask

    // any action, port and byte; the unused action code now and then
    task automatic send_noise();
        logic [1:0] act;
        act = ($urandom_range(0, 15) == 0) ? ACT_UNUSED : 2'($urandom_range(0, 2));
        send_item(act, 3'($urandom), 8'($urandom));
    endtask

    // stop offering and let every due result come back
    task automatic wait_drained();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && sink_stalls && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // watchdog: give up once nothing has moved for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         n;
        logic [1:0] acc;
        logic [7:0] ctrl;
        logic [7:0] b;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_WRITE;
        s_port_select = PORT_A;
        s_write_data  = 8'h00;
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        hold_req      = 1'b0;
        paused_once   = 1'b0;
        items_sent    = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---------------- directed part ----------------
        // count read straight after reset returns the zero latch
        read_port(PORT_COUNT);
        write_port(PORT_A, 8'hff);
        read_port(PORT_A);
        write_port(PORT_B, 8'h5a);
        read_port(PORT_B);
        read_port(PORT_STATUS);
        read_port(PORT_CONTROL);
        // writes to the status port are dropped
        write_port(PORT_STATUS, 8'hff);
        write_port(PORT_ENABLE0, 8'ha5);
        write_port(PORT_ENABLE1, 8'hff);
        read_port(PORT_ENABLE1);

        // key sequencer: arm at channel 0, deliver, falling bit 6 moves on
        write_port(PORT_C, 8'h80);
        write_port(PORT_C, 8'hc3);
        write_port(PORT_C, 8'h80);
        write_port(PORT_C, 8'h9e);
        read_port(PORT_C);

        // small count loads the full 65536, then latch and read both bytes
        write_port(PORT_CONTROL, {2'b00, ACC_LOW, OPMODE_RATE, 2'b00});
        write_port(PORT_COUNT, 8'h03);
        tick();
        write_port(PORT_CONTROL, {2'b00, ACC_LATCH, 4'b0000});
        read_port(PORT_COUNT);
        read_port(PORT_COUNT);

        // word load of 5 in rate mode: expires and reloads
        write_port(PORT_CONTROL, {2'b00, ACC_WORD, OPMODE_RATE, 2'b00});
        write_port(PORT_COUNT, 8'h05);
        write_port(PORT_COUNT, 8'h00);
        repeat (6) tick();
        send_item(ACT_UNUSED, PORT_C, 8'hff);

        wait_drained();

        // receiver holds off while the sender keeps offering, block backs up
        hold_req = 1'b1;
        repeat (20) send_noise();

        // ---------------- random part ----------------
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            // sender pause midway until nothing is due
            if (!paused_once && items_sent >= TOTAL_ITEMS / 2) begin
                paused_once = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // program the counter and clock it, mostly short counts
                    acc       = 2'($urandom_range(1, 3));
                    ctrl      = 8'($urandom);
                    ctrl[5:4] = acc;
                    if ($urandom_range(0, 1) == 1)
                        ctrl[3:2] = OPMODE_RATE;
                    write_port(PORT_CONTROL, ctrl);
                    b = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, 10));
                    case (acc)
                        ACC_LOW:  write_port(PORT_COUNT, b);
                        ACC_HIGH: write_port(PORT_COUNT, 8'($urandom));
                        default: begin
                            write_port(PORT_COUNT, b);
                            write_port(PORT_COUNT, ($urandom_range(0, 7) == 0) ?
                                                   8'($urandom) : 8'h00);
                        end
                    endcase
                    n = $urandom_range(1, 16);
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0)
                            read_port(PORT_COUNT);
                        tick();
                    end
                end
                4, 5: begin
                    // key walk: arm, deliver, then step through channels
                    b    = 8'($urandom);
                    b[7] = 1'b0;
                    write_port(PORT_C, b);
                    b    = 8'($urandom);
                    b[7] = 1'b1;
                    write_port(PORT_C, b);
                    b    = 8'($urandom);
                    b[7] = 1'b1;
                    write_port(PORT_C, b);
                    n = $urandom_range(0, 9);
                    repeat (n) begin
                        b      = 8'($urandom);
                        b[7:6] = 2'b11;
                        write_port(PORT_C, b);
                        b      = 8'($urandom);
                        b[7:6] = 2'b10;
                        write_port(PORT_C, b);
                        b    = 8'($urandom);
                        b[7] = 1'b1;
                        write_port(PORT_C, b);
                        if ($urandom_range(0, 3) == 0)
                            read_port(PORT_C);
                    end
                end
                6, 7: begin
                    // latch command, then read back the held count
                    ctrl      = 8'($urandom);
                    ctrl[5:4] = ACC_LATCH;
                    write_port(PORT_CONTROL, ctrl);
                    repeat ($urandom_range(1, 3)) read_port(PORT_COUNT);
                    if ($urandom_range(0, 1) == 1)
                        tick();
                end
                default: repeat ($urandom_range(1, 4)) send_noise();
            endcase
        end

        // ---------------- wind down ----------------
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: music_board_ports_with_interval_timer_unit.f
sv/mbp_pkg.sv
sv/mbp_timer.sv
sv/music_board_ports_with_interval_timer_unit.sv
sim/board_result_checker.sv
sim/testbench.sv
